// ===== sv/sorted_priority_queue_core_assert.svh =====
// Assertion macros for the sorted priority queue core
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, gated by reset
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spq: implication failed");

// next-cycle implication, gated by reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spq: next-cycle check failed");

`endif

// ===== sv/spq_pkg.sv =====
// Package: sizes, status codes and types for the sorted priority queue
package spq_pkg;

    localparam int CAPACITY       = 16;
    localparam int PRIORITY_WIDTH = 8;
    localparam int VALUE_W        = 32;
    localparam int IN_PRIO_W      = 8;
    localparam int ENTRY_COUNT_W  = 5;
    localparam int CNT_W          = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef logic [PRIORITY_WIDTH-1:0] t_prio;
    typedef logic [CNT_W-1:0]          t_count;

    typedef struct packed {
        logic                       valid;
        logic signed [VALUE_W-1:0]  value;
        t_prio                      prio;
    } t_slot;

    typedef struct packed {
        logic                       ins;
        logic                       rem;
        logic signed [VALUE_W-1:0]  value;
        t_prio                      prio;
    } t_cell_cmd;

    function automatic t_prio prio_of(logic [IN_PRIO_W-1:0] p);
        logic [IN_PRIO_W+PRIORITY_WIDTH-1:0] ext;
        ext = {{PRIORITY_WIDTH{1'b0}}, p};
        return ext[PRIORITY_WIDTH-1:0];
    endfunction

    function automatic logic [ENTRY_COUNT_W-1:0] count_out(t_count c);
        logic [CNT_W+ENTRY_COUNT_W-1:0] ext;
        ext = {{ENTRY_COUNT_W{1'b0}}, c};
        return ext[ENTRY_COUNT_W-1:0];
    endfunction

endpackage

// ===== sv/spq_req_if.sv =====
// Request channel: valid/ready with insert/remove payload
interface spq_req_if;
    import spq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic signed [VALUE_W-1:0]  item_value;
    logic [IN_PRIO_W-1:0]       item_priority;

    modport source (output valid, output req_type, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input req_type, input item_value, input item_priority,
                    output ready);
endinterface

// ===== sv/spq_rsp_if.sv =====
// Response channel: valid/ready with result payload
interface spq_rsp_if;
    import spq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  out_value;
    logic [1:0]                 status;
    logic                       now_empty;
    logic [ENTRY_COUNT_W-1:0]   entry_count;

    modport source (output valid, output out_value, output status, output now_empty,
                    output entry_count, input ready);
    modport sink   (input valid, input out_value, input status, input now_empty,
                    input entry_count, output ready);
endinterface

// ===== sv/spq_cell.sv =====
// One queue slot: keeps, takes the new entry, or shifts from a neighbour
module spq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  spq_pkg::t_slot    i_prev,
    input  logic              i_prev_ge,
    input  spq_pkg::t_slot    i_next,
    output spq_pkg::t_slot    o_slot,
    output logic              o_ge
);
    import spq_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    // entry stays ahead of the new one (equal priority keeps arrival order)
    assign o_ge   = r_slot.valid && (r_slot.prio >= i_cmd.prio);
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.ins) begin
            if (!o_ge) begin
                if (i_prev_ge) begin
                    n_slot.valid = 1'b1;
                    n_slot.value = i_cmd.value;
                    n_slot.prio  = i_cmd.prio;
                end else begin
                    n_slot = i_prev;
                end
            end
        end else if (i_cmd.rem) begin
            n_slot = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot.value <= n_slot.value;
        r_slot.prio  <= n_slot.prio;
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
    end

endmodule

// ===== sv/sorted_priority_queue_core.sv =====
// The result is registered and appears in the cycle after the request transfer.
// Throughput: one request per cycle while results are taken; the cell row updates all slots at once.
// Ready while the result register is empty or its contents are being taken.
// Reset (synchronous, active low): slot valid bits, entry count and result valid clear;
// slot values and priorities are left as they are.
`include "sorted_priority_queue_core_assert.svh"

module sorted_priority_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spq_req_if.sink     i_req,
    spq_rsp_if.source   o_rsp
);
    import spq_pkg::*;

    localparam t_slot HEAD_PREV = '{valid: 1'b1, value: '0, prio: '0};
    localparam t_slot TAIL_NEXT = '{valid: 1'b0, value: '0, prio: '0};

    t_slot     w_slot [CAPACITY];
    logic      w_ge   [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    t_cell_cmd w_cmd;
    logic      w_accept;
    logic      w_full;
    logic      w_empty;

    t_count    r_count;
    t_count    n_count;
    logic      r_rsp_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic signed [VALUE_W-1:0] n_out_value;
    logic [1:0] r_status;
    logic [1:0] n_status;

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == t_count'(CAPACITY));
    assign w_empty     = (r_count == '0);

    assign w_cmd.ins   = w_accept && (i_req.req_type == REQ_INSERT) && !w_full;
    assign w_cmd.rem   = w_accept && (i_req.req_type == REQ_REMOVE) && !w_empty;
    assign w_cmd.value = i_req.item_value;
    assign w_cmd.prio  = prio_of(i_req.item_priority);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_slot w_prev;
            t_slot w_next;
            logic  w_prev_ge;
            if (g == 0) begin : g_head
                assign w_prev    = HEAD_PREV;
                assign w_prev_ge = 1'b1;
            end else begin : g_body
                assign w_prev    = w_slot[g-1];
                assign w_prev_ge = w_ge[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign w_next = TAIL_NEXT;
            end else begin : g_mid
                assign w_next = w_slot[g+1];
            end
            spq_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (w_cmd),
                .i_prev    (w_prev),
                .i_prev_ge (w_prev_ge),
                .i_next    (w_next),
                .o_slot    (w_slot[g]),
                .o_ge      (w_ge[g])
            );
            assign w_valid[g] = w_slot[g].valid;
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_out_value = '0;
        if (i_req.req_type == REQ_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_INSERTED;
                n_count  = r_count + t_count'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status    = ST_REMOVED;
                n_count     = r_count - t_count'(1);
                n_out_value = w_slot[0].value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_value <= n_out_value;
            r_status    <= n_status;
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.out_value   = r_out_value;
    assign o_rsp.status      = r_status;
    assign o_rsp.now_empty   = (r_count == '0);
    assign o_rsp.entry_count = count_out(r_count);

    `SPQ_ASSERT_IMPLY(a_valid_matches_count, i_clk, i_rst_n, 1'b1,
                      $countones(w_valid) == r_count)
    `SPQ_ASSERT_NEXT(a_remove_decrements, i_clk, i_rst_n, w_cmd.rem,
                     r_count == $past(r_count) - t_count'(1))
    `SPQ_ASSERT_IMPLY(a_head_sorted, i_clk, i_rst_n, w_slot[0].valid && w_slot[1].valid,
                      w_slot[0].prio >= w_slot[1].prio)

endmodule
